@@ sv/binary_heap_priority_queue_macros.svh @@
// Assertion macros for the heap queue RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bhpq_pkg.sv @@
// Package for the binary heap priority queue: codes, FSM states and the
// command and status structs between controller and datapath. No dependencies.
package bhpq_pkg;

  localparam int KEY_PORT_W   = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 11;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_DONE  = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2
  } res_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_LOAD,
    ST_DN_CHK,
    ST_DN_CMP
  } state_t;

  // Which addresses the two memory read ports look at.
  typedef enum logic [1:0] {
    RD_POP,
    RD_PARENT,
    RD_KIDS
  } rd_sel_t;

  // What the single memory write port stores at the hole position.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_VAL,
    WR_UP,
    WR_DN
  } wr_sel_t;

  typedef struct packed {
    logic        ld_push;
    logic        ld_pop;
    logic        ld_root;
    rd_sel_t     rd_sel;
    wr_sel_t     wr_sel;
    logic        report;
    res_status_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_move;
    logic left_ok;
    logic dn_move;
  } dp_stat_t;

endpackage

@@ sv/bhpq_ctrl.sv @@
// Controller state machine for the heap queue: sequences push sift-up and
// pop sift-down steps. Depends on bhpq_pkg.
module bhpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               opcode,
  input  bhpq_pkg::dp_stat_t stat,
  output bhpq_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import bhpq_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '{ld_push: 1'b0, ld_pop: 1'b0, ld_root: 1'b0, rd_sel: RD_POP,
                   wr_sel: WR_NONE, report: 1'b0, res: RES_DONE};
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (opcode_t'(opcode) == OP_PUSH) begin
            if (stat.full) begin
              cmd.report = 1'b1;
              cmd.res    = RES_FULL;
            end else begin
              cmd.ld_push = 1'b1;
              state_next  = ST_UP_CHK;
            end
          end else begin
            if (stat.empty) begin
              cmd.report = 1'b1;
              cmd.res    = RES_EMPTY;
            end else begin
              cmd.ld_pop = 1'b1;
              cmd.rd_sel = RD_POP;
              state_next = ST_POP_LOAD;
            end
          end
        end
      end
      ST_UP_CHK: begin
        if (stat.pos_zero) begin
          cmd.wr_sel = WR_VAL;
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (stat.up_move) begin
          cmd.wr_sel = WR_UP;
          state_next = ST_UP_CHK;
        end else begin
          cmd.wr_sel = WR_VAL;
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_POP_LOAD: begin
        cmd.ld_root = 1'b1;
        state_next  = ST_DN_CHK;
      end
      ST_DN_CHK: begin
        if (!stat.left_ok) begin
          cmd.wr_sel = WR_VAL;
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.rd_sel = RD_KIDS;
          state_next = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        if (stat.dn_move) begin
          cmd.wr_sel = WR_DN;
          state_next = ST_DN_CHK;
        end else begin
          cmd.wr_sel = WR_VAL;
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/bhpq_dp.sv @@
// Datapath for the heap queue: key memory, hole position, moving key,
// element count, order register and result registers. Depends on bhpq_pkg
// and binary_heap_priority_queue_macros.svh.
`include "binary_heap_priority_queue_macros.svh"

module bhpq_dp #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_data,
  input  logic [bhpq_pkg::KEY_PORT_W-1:0]     key,
  input  bhpq_pkg::dp_cmd_t                   cmd,
  output bhpq_pkg::dp_stat_t                  stat,
  output logic                                done,
  output logic [bhpq_pkg::KEY_PORT_W-1:0]     popped_key,
  output logic [bhpq_pkg::STATUS_W-1:0]       status,
  output logic [bhpq_pkg::COUNT_PORT_W-1:0]   count
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic [CW-1:0]        elem_count;
  logic [AW-1:0]        pos;
  logic [KEY_WIDTH-1:0] val;
  logic [KEY_WIDTH-1:0] popped;
  logic [KEY_WIDTH-1:0] rd_a;
  logic [KEY_WIDTH-1:0] rd_b;
  logic                 order;

  logic [AW:0]          left_w;
  logic [AW:0]          right_w;
  logic                 left_ok;
  logic                 right_ok;
  logic [AW-1:0]        parent;
  logic                 kid_right;
  logic [KEY_WIDTH-1:0] kid_val;
  logic [AW-1:0]        kid_pos;
  logic [AW-1:0]        addr_a;
  logic [AW-1:0]        addr_b;
  logic [KEY_WIDTH-1:0] wr_data;

  // True when key a belongs strictly above key b under the current order.
  function automatic logic ranks_before(input logic [KEY_WIDTH-1:0] a,
                                        input logic [KEY_WIDTH-1:0] b,
                                        input logic                 max_mode);
    ranks_before = max_mode ? (a > b) : (a < b);
  endfunction

  // Tree neighbors of the hole.
  assign left_w   = {pos, 1'b1};
  assign right_w  = {pos, 1'b0} + (AW+1)'(2);
  assign left_ok  = (CW+1)'(left_w) < (CW+1)'(elem_count);
  assign right_ok = (CW+1)'(right_w) < (CW+1)'(elem_count);
  assign parent   = AW'((pos - AW'(1)) >> 1);

  // Child selection on sift-down; ties pick the left child.
  assign kid_right = right_ok && ranks_before(rd_b, rd_a, order);
  assign kid_val   = kid_right ? rd_b : rd_a;
  assign kid_pos   = kid_right ? AW'(right_w) : AW'(left_w);

  // Status toward the controller.
  assign stat.full     = (elem_count == CW'(CAPACITY));
  assign stat.empty    = (elem_count == '0);
  assign stat.pos_zero = (pos == '0);
  assign stat.up_move  = ranks_before(val, rd_a, order);
  assign stat.left_ok  = left_ok;
  assign stat.dn_move  = ranks_before(kid_val, val, order);

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_POP: begin
        addr_a = '0;
        addr_b = AW'(elem_count - CW'(1));
      end
      RD_PARENT: begin
        addr_a = parent;
        addr_b = parent;
      end
      RD_KIDS: begin
        addr_a = AW'(left_w);
        addr_b = right_ok ? AW'(right_w) : AW'(left_w);
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  // Write data selection.
  always_comb begin
    unique case (cmd.wr_sel)
      WR_UP:   wr_data = rd_a;
      WR_DN:   wr_data = kid_val;
      default: wr_data = val;
    endcase
  end

  // Key memory: one write port at the hole, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      mem[pos] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Hole position, moving key and popped root.
  always_ff @(posedge clk) begin
    if (cmd.ld_push) begin
      pos    <= AW'(elem_count);
      val    <= KEY_WIDTH'(key);
      popped <= '0;
    end else if (cmd.ld_root) begin
      pos    <= '0;
      val    <= rd_b;
      popped <= rd_a;
    end else if (cmd.wr_sel == WR_UP) begin
      pos <= parent;
    end else if (cmd.wr_sel == WR_DN) begin
      pos <= kid_pos;
    end
  end

  // Element count and order register.
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      order      <= 1'b0;
    end else begin
      if (cfg_we) begin
        order <= cfg_data;
      end
      if (cmd.ld_push) begin
        elem_count <= elem_count + CW'(1);
      end else if (cmd.ld_pop) begin
        elem_count <= elem_count - CW'(1);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      status     <= cmd.res;
      popped_key <= (cmd.res == RES_DONE) ? KEY_PORT_W'(popped) : '0;
    end
  end

  assign count = COUNT_PORT_W'(elem_count);

  // A refused push only happens at capacity, a refused pop only when empty.
  `BHPQ_ASSERT_NOW(a_full_count, done && (status == RES_FULL), elem_count == CW'(CAPACITY), "full reported below capacity")
  `BHPQ_ASSERT_NOW(a_empty_count, done && (status == RES_EMPTY), elem_count == '0, "empty reported with keys held")
  // Sifting up always moves the hole toward the root.
  `BHPQ_ASSERT_NEXT(a_up_rises, cmd.wr_sel == WR_UP, pos < $past(pos), "sift-up did not rise")
  // Sifting down only moves into an existing child.
  `BHPQ_ASSERT_NOW(a_dn_child, cmd.wr_sel == WR_DN, left_ok, "sift-down past last entry")

endmodule

@@ sv/binary_heap_priority_queue.sv @@
// Binary heap priority queue, min or max order chosen by cfg_data.
// A refused push or pop gives its result in the cycle after start.
// A push or pop handles each tree level as a memory read, then compare and write.
// busy stays high until the result strobe, so a new request can follow in that cycle.
// Synchronous reset empties the heap and selects min order; memory is not cleared.
module binary_heap_priority_queue #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic [bhpq_pkg::KEY_PORT_W-1:0]   key,
  input  logic                              cfg_we,
  input  logic                              cfg_data,
  output logic                              done,
  output logic [bhpq_pkg::KEY_PORT_W-1:0]   popped_key,
  output logic [bhpq_pkg::STATUS_W-1:0]     status,
  output logic [bhpq_pkg::COUNT_PORT_W-1:0] count
);
  import bhpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer for sift steps.
  bhpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Memory, compare logic and result registers.
  bhpq_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .key        (key),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .popped_key (popped_key),
    .status     (status),
    .count      (count)
  );

endmodule
